// ===== rtl/core/owbsm_pkg.sv =====
// Shared types and constants for the one-wire bit-slot master.
// Used by owbsm_engine and one_wire_bit_slot_master; depends on nothing.
package owbsm_pkg;

	localparam int unsigned TimerWidth = 10;

	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_RESET  = 3'd1,
		OP_WBIT   = 3'd2,
		OP_RBIT   = 3'd3,
		OP_WBYTE  = 3'd4,
		OP_RBYTE  = 3'd5
	} opcode_t;

	typedef enum logic [2:0] {
		REG_SEPARATOR   = 3'd0,
		REG_RESET_LOW   = 3'd1,
		REG_PRES_SAMPLE = 3'd2,
		REG_PRES_WAIT   = 3'd3,
		REG_SLOT_BEGIN  = 3'd4,
		REG_READ_SAMPLE = 3'd5,
		REG_SLOT        = 3'd6
	} reg_index_t;

	typedef struct packed {
		logic [7:0] separator_us;
		logic [9:0] reset_low_us;
		logic [5:0] presence_sample_us;
		logic [7:0] presence_wait_us;
		logic [3:0] slot_begin_us;
		logic [3:0] read_sample_us;
		logic [6:0] slot_us;
	} cfg_t;

	localparam cfg_t CfgReset = '{
		separator_us:       8'd2,
		reset_low_us:       10'd500,
		presence_sample_us: 6'd30,
		presence_wait_us:   8'd240,
		slot_begin_us:      4'd2,
		read_sample_us:     4'd10,
		slot_us:            7'd60
	};

	typedef struct packed {
		logic       presence;
		logic [7:0] read_data;
		logic       rejected;
		logic       done_res;
		logic       busy_res;
		logic       bus_pull_low;
	} result_t;

endpackage

// ===== rtl/core/owbsm_engine.sv =====
// Bit-slot sequencer of the one-wire master: phase state, tick and bit counters.
// Produces the result of the current tick combinationally; depends on owbsm_pkg.
module owbsm_engine (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  logic [2:0]        opcode,
	input  logic [7:0]        data_byte,
	input  logic              line_level,
	input  owbsm_pkg::cfg_t   cfg,
	output owbsm_pkg::result_t result
);

	typedef enum logic [2:0] {
		PH_IDLE = 3'd0,
		PH_SEP  = 3'd1,
		PH_LOW  = 3'd2,
		PH_DATA = 3'd3,
		PH_WAIT = 3'd4,
		PH_TAIL = 3'd5
	} phase_t;

	localparam int unsigned TW = owbsm_pkg::TimerWidth;

	phase_t                phase_q, phase_d;
	logic [TW-1:0]         tick_q, tick_d;
	logic [2:0]            bit_q, bit_d;
	logic [7:0]            shift_q, shift_d;
	logic [2:0]            cmd_q, cmd_d;
	logic                  pres_q, pres_d;
	logic [7:0]            rdata_q, rdata_d;

	logic                  rst_cmd, wr_cmd, byte_cmd, last, slot_end;
	logic [TW-1:0]         len;
	logic [7:0]            data_len, tail_len, begin_sum;
	logic [TW:0]           tick_inc;

	always_comb begin
		phase_d = phase_q;
		tick_d = tick_q;
		bit_d = bit_q;
		shift_d = shift_q;
		cmd_d = cmd_q;
		pres_d = pres_q;
		rdata_d = rdata_q;
		result = '0;
		slot_end = 1'b0;

		if (phase_q != PH_IDLE) begin
			result.rejected = (opcode != owbsm_pkg::OP_TICK);
		end else if (opcode >= owbsm_pkg::OP_RESET && opcode <= owbsm_pkg::OP_RBYTE) begin
			cmd_d = opcode;
			bit_d = 3'd0;
			shift_d = (opcode == owbsm_pkg::OP_WBIT || opcode == owbsm_pkg::OP_WBYTE)
				? data_byte : 8'd0;
			phase_d = PH_SEP;
			tick_d = '0;
		end

		rst_cmd = (cmd_d == owbsm_pkg::OP_RESET);
		wr_cmd = (cmd_d == owbsm_pkg::OP_WBIT) || (cmd_d == owbsm_pkg::OP_WBYTE);
		byte_cmd = (cmd_d == owbsm_pkg::OP_WBYTE) || (cmd_d == owbsm_pkg::OP_RBYTE);

		data_len = (cfg.slot_us > {3'd0, cfg.slot_begin_us})
			? {1'b0, cfg.slot_us} - {4'd0, cfg.slot_begin_us} : 8'd1;
		begin_sum = {4'd0, cfg.slot_begin_us} + {4'd0, cfg.read_sample_us};
		tail_len = ({1'b0, cfg.slot_us} > begin_sum)
			? {1'b0, cfg.slot_us} - begin_sum : 8'd1;

		unique case (phase_d)
			PH_SEP:  len = TW'(cfg.separator_us);
			PH_LOW:  len = rst_cmd ? TW'(cfg.reset_low_us) : TW'(cfg.slot_begin_us);
			PH_DATA: len = TW'(data_len);
			PH_WAIT: len = rst_cmd ? TW'(cfg.presence_sample_us) : TW'(cfg.read_sample_us);
			PH_TAIL: len = rst_cmd ? TW'(cfg.presence_wait_us) : TW'(tail_len);
			default: len = TW'(1);
		endcase
		if (len == '0) begin
			len = TW'(1);
		end

		tick_inc = {1'b0, tick_d} + (TW+1)'(1);
		last = (tick_inc >= {1'b0, len});

		if (phase_d != PH_IDLE) begin
			result.busy_res = 1'b1;
			if (phase_d == PH_LOW) begin
				result.bus_pull_low = 1'b1;
			end else if (phase_d == PH_DATA) begin
				result.bus_pull_low = ~shift_d[0];
			end

			if (last) begin
				tick_d = '0;
				unique case (phase_d)
					PH_SEP:  phase_d = PH_LOW;
					PH_LOW:  phase_d = (!rst_cmd && wr_cmd) ? PH_DATA : PH_WAIT;
					PH_DATA: slot_end = 1'b1;
					PH_WAIT: begin
						if (rst_cmd) begin
							shift_d = {7'd0, ~line_level};
						end else begin
							shift_d = {line_level, shift_d[7:1]};
						end
						phase_d = PH_TAIL;
					end
					PH_TAIL: begin
						if (rst_cmd) begin
							pres_d = shift_d[0];
							phase_d = PH_IDLE;
							result.done_res = 1'b1;
						end else begin
							slot_end = 1'b1;
						end
					end
					default: phase_d = PH_IDLE;
				endcase
				if (slot_end) begin
					if (!byte_cmd || bit_d == 3'd7) begin
						if (cmd_d == owbsm_pkg::OP_RBIT) begin
							rdata_d = {7'd0, shift_d[7]};
						end else if (cmd_d == owbsm_pkg::OP_RBYTE) begin
							rdata_d = shift_d;
						end
						phase_d = PH_IDLE;
						result.done_res = 1'b1;
					end else begin
						bit_d = bit_d + 3'd1;
						if (wr_cmd) begin
							shift_d = {1'b0, shift_d[7:1]};
						end
						phase_d = PH_SEP;
					end
				end
			end else begin
				tick_d = tick_inc[TW-1:0];
			end
		end

		result.read_data = rdata_d;
		result.presence = pres_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			tick_q <= '0;
			bit_q <= 3'd0;
			shift_q <= 8'd0;
			cmd_q <= 3'd0;
			pres_q <= 1'b0;
			rdata_q <= 8'd0;
		end else if (step) begin
			phase_q <= phase_d;
			tick_q <= tick_d;
			bit_q <= bit_d;
			shift_q <= shift_d;
			cmd_q <= cmd_d;
			pres_q <= pres_d;
			rdata_q <= rdata_d;
		end
	end

endmodule

// ===== rtl/core/one_wire_bit_slot_master.sv =====
// Top level of the one-wire bit-slot master: stream ports, timing registers
// and result register around owbsm_engine; depends on owbsm_pkg.
//
// Each input item is one microsecond tick carrying an opcode, a byte to write
// and the sampled bus level; each tick yields exactly one result item with the
// pull-low drive, busy, done, rejected, last read data and presence flag.
// An opcode from 1 to 5 starts a command when the engine is idle; any nonzero
// opcode is rejected while a command runs.
// The result of an item is in the output register on the cycle after it is
// accepted. One item is taken per cycle unless the output is stalled; the
// sequencer state and the result register are both updated as it is taken.
// The input is taken whenever the output register is empty or being emptied,
// so a stalled receiver holds the result and back-pressures the input side.
// Timing registers are written through the cfg port, which is always ready;
// indexes beyond the list are ignored. Writes are meant to occur while idle.
// Reset returns the sequencer to idle, clears the read data and presence flag,
// loads the default timings and empties the output register.
module one_wire_bit_slot_master (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,   // opcode[2:0], data_byte[10:3], line_level[11], zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [15:0] m_tdata,   // bus_pull_low[0], busy_res[1], done_res[2],
	                               // rejected[3], read_data[11:4], presence[12], zero
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [2:0]  cfg_index,
	input  logic [9:0]  cfg_data
);

	owbsm_pkg::cfg_t    cfg_q;
	owbsm_pkg::result_t result;
	owbsm_pkg::result_t result_q;
	logic               valid_q;
	logic               accept;

	assign s_tready = !valid_q || m_tready;
	assign accept = s_tvalid && s_tready;
	assign cfg_ready = 1'b1;

	owbsm_engine u_engine (
		.clk        (clk),
		.arst_n     (arst_n),
		.step       (accept),
		.opcode     (s_tdata[2:0]),
		.data_byte  (s_tdata[10:3]),
		.line_level (s_tdata[11]),
		.cfg        (cfg_q),
		.result     (result)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= owbsm_pkg::CfgReset;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				owbsm_pkg::REG_SEPARATOR:   cfg_q.separator_us <= cfg_data[7:0];
				owbsm_pkg::REG_RESET_LOW:   cfg_q.reset_low_us <= cfg_data;
				owbsm_pkg::REG_PRES_SAMPLE: cfg_q.presence_sample_us <= cfg_data[5:0];
				owbsm_pkg::REG_PRES_WAIT:   cfg_q.presence_wait_us <= cfg_data[7:0];
				owbsm_pkg::REG_SLOT_BEGIN:  cfg_q.slot_begin_us <= cfg_data[3:0];
				owbsm_pkg::REG_READ_SAMPLE: cfg_q.read_sample_us <= cfg_data[3:0];
				owbsm_pkg::REG_SLOT:        cfg_q.slot_us <= cfg_data[6:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (accept) begin
			valid_q <= 1'b1;
		end else if (m_tready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			result_q <= result;
		end
	end

	assign m_tvalid = valid_q;
	assign m_tdata = {3'd0, result_q};

endmodule

// ===== dv/testbench.sv =====
// Self-checking testbench for one_wire_bit_slot_master: drives tick items and timing writes,
// predicts every result item in a scoreboard class and compares it field by field.
// Depends on owbsm_pkg and the one_wire_bit_slot_master RTL.
module testbench;

	localparam int CycleLimit = 1000000;
	localparam logic [2:0] OpSpareLow = 3'd6;
	localparam logic [2:0] OpSpareHigh = 3'd7;
	localparam logic [2:0] RegUnused = 3'd7;

	typedef enum logic [2:0] {
		SEQ_IDLE, SEQ_SEP, SEQ_LOW, SEQ_DATA, SEQ_WAIT, SEQ_TAIL
	} slot_phase_t;

	typedef enum int {TIM_ZERO, TIM_SMALL, TIM_RANGE_LOW} timing_kind_t;
	typedef enum int {LINE_LOW, LINE_HIGH, LINE_RANDOM} line_mode_t;

	class bit_slot_scoreboard;
		owbsm_pkg::cfg_t timing;
		slot_phase_t phase;
		int unsigned tick_cnt;
		logic [2:0] bit_cnt;
		logic [7:0] shreg;
		logic [2:0] cmd;
		logic presence_flag;
		logic [7:0] read_byte;
		owbsm_pkg::result_t tick_results[$];
		int errors;

		function new();
			timing = owbsm_pkg::CfgReset;
			phase = SEQ_IDLE;
			tick_cnt = 0;
			bit_cnt = '0;
			shreg = '0;
			cmd = '0;
			presence_flag = 1'b0;
			read_byte = '0;
			errors = 0;
		endfunction

		function void write_config(logic [2:0] idx, logic [9:0] value);
			unique case (idx)
				owbsm_pkg::REG_SEPARATOR:   timing.separator_us = value[7:0];
				owbsm_pkg::REG_RESET_LOW:   timing.reset_low_us = value;
				owbsm_pkg::REG_PRES_SAMPLE: timing.presence_sample_us = value[5:0];
				owbsm_pkg::REG_PRES_WAIT:   timing.presence_wait_us = value[7:0];
				owbsm_pkg::REG_SLOT_BEGIN:  timing.slot_begin_us = value[3:0];
				owbsm_pkg::REG_READ_SAMPLE: timing.read_sample_us = value[3:0];
				owbsm_pkg::REG_SLOT:        timing.slot_us = value[6:0];
				default: ;
			endcase
		endfunction

		function int unsigned phase_length();
			int unsigned n;
			int unsigned slot, slot_begin, read_at;
			bit is_reset;
			is_reset = (cmd == owbsm_pkg::OP_RESET);
			slot = 32'(timing.slot_us);
			slot_begin = 32'(timing.slot_begin_us);
			read_at = 32'(timing.read_sample_us);
			unique case (phase)
				SEQ_SEP: n = 32'(timing.separator_us);
				SEQ_LOW: n = is_reset ? 32'(timing.reset_low_us) : slot_begin;
				SEQ_DATA: n = (slot > slot_begin) ? slot - slot_begin : 1;
				SEQ_WAIT: n = is_reset ? 32'(timing.presence_sample_us) : read_at;
				SEQ_TAIL: begin
					if (is_reset) begin
						n = 32'(timing.presence_wait_us);
					end else begin
						n = (slot > slot_begin + read_at) ? slot - slot_begin - read_at : 1;
					end
				end
				default: n = 1;
			endcase
			return (n == 0) ? 1 : n;
		endfunction

		// Advances the predicted sequencer by one accepted tick and queues its result.
		function void note_tick(logic [2:0] op, logic [7:0] data, logic line);
			owbsm_pkg::result_t r;
			int unsigned len;
			bit is_reset, is_write, is_byte, slot_end;
			r = '0;
			if (phase != SEQ_IDLE) begin
				if (op != owbsm_pkg::OP_TICK) r.rejected = 1'b1;
			end else if (op >= owbsm_pkg::OP_RESET && op <= owbsm_pkg::OP_RBYTE) begin
				cmd = op;
				bit_cnt = '0;
				shreg = (op == owbsm_pkg::OP_WBIT || op == owbsm_pkg::OP_WBYTE) ? data : 8'h00;
				phase = SEQ_SEP;
				tick_cnt = 0;
			end
			if (phase != SEQ_IDLE) begin
				is_reset = (cmd == owbsm_pkg::OP_RESET);
				is_write = (cmd == owbsm_pkg::OP_WBIT || cmd == owbsm_pkg::OP_WBYTE);
				is_byte = (cmd == owbsm_pkg::OP_WBYTE || cmd == owbsm_pkg::OP_RBYTE);
				len = phase_length();
				slot_end = 1'b0;
				r.busy_res = 1'b1;
				if (phase == SEQ_LOW) begin
					r.bus_pull_low = 1'b1;
				end else if (phase == SEQ_DATA) begin
					r.bus_pull_low = !shreg[0];
				end
				if (tick_cnt + 1 >= len) begin
					tick_cnt = 0;
					unique case (phase)
						SEQ_SEP: phase = SEQ_LOW;
						SEQ_LOW: phase = (!is_reset && is_write) ? SEQ_DATA : SEQ_WAIT;
						SEQ_DATA: slot_end = 1'b1;
						SEQ_WAIT: begin
							if (is_reset) begin
								shreg = line ? 8'h00 : 8'h01;
							end else begin
								shreg = {line, shreg[7:1]};
							end
							phase = SEQ_TAIL;
						end
						SEQ_TAIL: begin
							if (is_reset) begin
								presence_flag = shreg[0];
								phase = SEQ_IDLE;
								r.done_res = 1'b1;
							end else begin
								slot_end = 1'b1;
							end
						end
						default: phase = SEQ_IDLE;
					endcase
					if (slot_end) begin
						if (!is_byte || bit_cnt == 3'd7) begin
							if (cmd == owbsm_pkg::OP_RBIT) begin
								read_byte = {7'b0, shreg[7]};
							end else if (cmd == owbsm_pkg::OP_RBYTE) begin
								read_byte = shreg;
							end
							phase = SEQ_IDLE;
							r.done_res = 1'b1;
						end else begin
							bit_cnt = bit_cnt + 3'd1;
							if (is_write) shreg = shreg >> 1;
							phase = SEQ_SEP;
						end
					end
				end else begin
					tick_cnt = (tick_cnt + 1) & ((1 << owbsm_pkg::TimerWidth) - 1);
				end
			end
			r.read_data = read_byte;
			r.presence = presence_flag;
			tick_results.push_back(r);
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$error("%s expected %0h got %0h", name, want, got);
				errors++;
			end
		endfunction

		function void check_result(logic [15:0] word);
			owbsm_pkg::result_t want, got;
			if (tick_results.size() == 0) begin
				$error("result item arrived with no tick awaiting it");
				errors++;
				return;
			end
			want = tick_results.pop_front();
			got = owbsm_pkg::result_t'(word[12:0]);
			compare_field("bus_pull_low", 8'(want.bus_pull_low), 8'(got.bus_pull_low));
			compare_field("busy_res", 8'(want.busy_res), 8'(got.busy_res));
			compare_field("done_res", 8'(want.done_res), 8'(got.done_res));
			compare_field("rejected", 8'(want.rejected), 8'(got.rejected));
			compare_field("read_data", want.read_data, got.read_data);
			compare_field("presence", 8'(want.presence), 8'(got.presence));
			compare_field("padding", 8'h00, {5'b0, word[15:13]});
		endfunction

		function bit is_idle();
			return phase == SEQ_IDLE;
		endfunction

		function int pending();
			return tick_results.size();
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [15:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [15:0] m_tdata;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [2:0] cfg_index = '0;
	logic [9:0] cfg_data = '0;

	int send_idle_pct = 37;
	int recv_idle_pct = 64;
	int cycle_count = 0;
	bit_slot_scoreboard board;

	one_wire_bit_slot_master dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #5 clk = ~clk;

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CycleLimit) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata);
		m_tready <= ($urandom_range(99) >= recv_idle_pct);
	end

	function automatic logic pick_line(line_mode_t mode);
		unique case (mode)
			LINE_LOW: return 1'b0;
			LINE_HIGH: return 1'b1;
			default: return 1'($urandom_range(1));
		endcase
	endfunction

	task automatic send_tick(input logic [2:0] op, input logic [7:0] data, input logic line);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata <= {4'b0, line, data, op};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		board.note_tick(op, data, line);
	endtask

	task automatic run_command(input logic [2:0] op, input logic [7:0] data,
			input line_mode_t mode, input bit poke_busy);
		send_tick(op, data, pick_line(mode));
		if (poke_busy) begin
			for (int k = owbsm_pkg::OP_RESET; k <= OpSpareHigh; k++) begin
				send_tick(k[2:0], 8'($urandom), pick_line(mode));
			end
		end
		while (!board.is_idle()) send_tick(owbsm_pkg::OP_TICK, 8'($urandom), pick_line(mode));
	endtask

	// Lets the running command finish and every result drain before timings change.
	task automatic settle_idle();
		while (!board.is_idle()) begin
			send_tick(owbsm_pkg::OP_TICK, 8'($urandom), pick_line(LINE_RANDOM));
		end
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (board.pending() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic put_reg(input logic [2:0] idx, input logic [9:0] value);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		board.write_config(idx, value);
	endtask

	task automatic load_timing(input owbsm_pkg::cfg_t t);
		put_reg(owbsm_pkg::REG_SEPARATOR, 10'(t.separator_us));
		put_reg(owbsm_pkg::REG_RESET_LOW, t.reset_low_us);
		put_reg(owbsm_pkg::REG_PRES_SAMPLE, 10'(t.presence_sample_us));
		put_reg(owbsm_pkg::REG_PRES_WAIT, 10'(t.presence_wait_us));
		put_reg(owbsm_pkg::REG_SLOT_BEGIN, 10'(t.slot_begin_us));
		put_reg(owbsm_pkg::REG_READ_SAMPLE, 10'(t.read_sample_us));
		put_reg(owbsm_pkg::REG_SLOT, 10'(t.slot_us));
		put_reg(RegUnused, 10'($urandom));
		cfg_valid <= 1'b0;
		@(posedge clk);
	endtask

	function automatic owbsm_pkg::cfg_t make_timing(timing_kind_t kind);
		owbsm_pkg::cfg_t t;
		unique case (kind)
			TIM_ZERO: t = '0;
			TIM_RANGE_LOW: t = '{8'd1, 10'd480, 6'd15, 8'd60, 4'd1, 4'd1, 7'd60};
			default: begin
				t.separator_us = 8'($urandom_range(3));
				t.reset_low_us = 10'($urandom_range(6));
				t.presence_sample_us = 6'($urandom_range(4));
				t.presence_wait_us = 8'($urandom_range(4));
				t.slot_begin_us = 4'($urandom_range(4));
				t.read_sample_us = 4'($urandom_range(4));
				t.slot_us = 7'($urandom_range(12));
			end
		endcase
		return t;
	endfunction

	initial begin
		timing_kind_t plan[9];
		int items;
		int pick;
		logic [2:0] op;
		plan = '{TIM_ZERO, TIM_SMALL, TIM_RANGE_LOW, TIM_SMALL, TIM_SMALL, TIM_SMALL,
			TIM_SMALL, TIM_SMALL, TIM_SMALL};
		board = new();
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part at the reset timings.
		send_tick(owbsm_pkg::OP_TICK, 8'hFF, 1'b1);
		send_tick(OpSpareLow, 8'h00, 1'b0);
		send_tick(OpSpareHigh, 8'hFF, 1'b1);
		run_command(owbsm_pkg::OP_RESET, 8'h00, LINE_LOW, 1'b0);
		run_command(owbsm_pkg::OP_WBIT, 8'h01, LINE_RANDOM, 1'b1);
		run_command(owbsm_pkg::OP_RBIT, 8'hFF, LINE_LOW, 1'b0);

		for (int ph = 0; ph < 9; ph++) begin
			settle_idle();
			unique case (ph / 3)
				0: begin
					send_idle_pct = 37;
					recv_idle_pct = 64;
				end
				1: begin
					send_idle_pct = 64;
					recv_idle_pct = 37;
				end
				default: begin
					send_idle_pct = 0;
					recv_idle_pct = 0;
				end
			endcase
			load_timing(make_timing(plan[ph]));
			items = (plan[ph] == TIM_RANGE_LOW) ? 20 : 80;
			for (int i = 0; i < items; i++) begin
				if (board.is_idle()) begin
					pick = $urandom_range(99);
					if (pick < 55) begin
						op = 3'($urandom_range(owbsm_pkg::OP_RBYTE, owbsm_pkg::OP_RESET));
					end else if (pick < 65) begin
						op = 3'($urandom_range(OpSpareHigh, OpSpareLow));
					end else begin
						op = owbsm_pkg::OP_TICK;
					end
				end else begin
					op = ($urandom_range(99) < 6)
						? 3'($urandom_range(OpSpareHigh, owbsm_pkg::OP_RESET))
						: owbsm_pkg::OP_TICK;
				end
				send_tick(op, 8'($urandom), pick_line(LINE_RANDOM));
				if (i == items / 2) begin
					s_tvalid <= 1'b0;
					@(posedge clk);
					while (board.pending() != 0) @(posedge clk);
				end
			end
		end

		settle_idle();
		repeat (10) @(posedge clk);
		if (board.errors == 0 && board.pending() == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule

// ===== one_wire_bit_slot_master.f =====
rtl/core/owbsm_pkg.sv
rtl/core/owbsm_engine.sv
rtl/core/one_wire_bit_slot_master.sv
dv/testbench.sv
